@@ hw/rtl/assert_macros.svh @@
// Shared assertion macros. Each expects clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cgc_pkg.sv @@
`default_nettype none

package cgc_pkg;

	localparam int COORD_BITS = 12;
	localparam int COL_W      = COORD_BITS + 1;
	localparam int CHAN_W     = 8;
	localparam int NUM_CHAN   = 3;
	localparam int COLOR_W    = CHAN_W * NUM_CHAN;
	localparam int PROD_W     = COORD_BITS + CHAN_W;
	localparam int DVS_W      = PROD_W + 1;
	localparam int NUM_CELLS  = CHAN_W;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [COLOR_W-1:0] START_COLOR_RST = 24'h0A246A;
	localparam logic [COLOR_W-1:0] END_COLOR_RST   = 24'hA6CAF0;

	typedef enum logic {
		REG_START_COLOR = 1'b0,
		REG_END_COLOR   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_START,
		MODE_END,
		MODE_BLEND
	} mode_t;

	// One column word as it walks the divider chain.
	typedef struct packed {
		logic [COL_W-1:0]                     col;
		logic [COORD_BITS-1:0]                top;
		logic [COORD_BITS-1:0]                height;
		mode_t                                mode;
		logic [NUM_CHAN-1:0]                  neg;
		logic [DVS_W-1:0]                     dvs;
		logic [NUM_CHAN-1:0][PROD_W-1:0]      rem;
		logic [NUM_CHAN-1:0][CHAN_W-1:0]      quo;
	} tok_t;

endpackage

`default_nettype wire

@@ hw/rtl/cgc_front.sv @@
`default_nettype none

module cgc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cgc_pkg::COL_W-1:0]         column,
	input  logic [cgc_pkg::COORD_BITS-1:0]    caption_left,
	input  logic [cgc_pkg::COORD_BITS-1:0]    caption_width,
	input  logic [cgc_pkg::COORD_BITS-1:0]    icon_width,
	input  logic [cgc_pkg::COORD_BITS-1:0]    buttons_width,
	input  logic [cgc_pkg::COORD_BITS-1:0]    top,
	input  logic [cgc_pkg::COORD_BITS-1:0]    height,
	input  logic [cgc_pkg::COLOR_W-1:0]       start_color,
	input  logic [cgc_pkg::COLOR_W-1:0]       end_color,
	output logic                              tok_vld,
	input  logic                              tok_rdy,
	output cgc_pkg::tok_t                     tok
);

	// stage 1: bar test, ramp start and span
	logic [cgc_pkg::COL_W-1:0]        bar_end;
	logic [cgc_pkg::COL_W-1:0]        rs_c;
	logic [cgc_pkg::COORD_BITS-1:0]   mn_c;
	logic [cgc_pkg::COORD_BITS+1:0]   rest_c;
	logic [cgc_pkg::COORD_BITS-1:0]   span_c;
	logic                             in_bar;

	logic                             v_s1, v_s2, v_s3;
	logic                             rdy1, rdy2, rdy3;
	logic [cgc_pkg::COL_W-1:0]        col_s1, rs_s1, col_s2;
	logic [cgc_pkg::COORD_BITS-1:0]   span_s1, top_s1, height_s1;
	logic [cgc_pkg::COORD_BITS-1:0]   span_s2, top_s2, height_s2, d_s2;
	cgc_pkg::mode_t                   mode_s2;
	cgc_pkg::tok_t                    tok_s3;

	// stage 2: classify the column
	logic [cgc_pkg::COL_W:0]          dd_c;
	cgc_pkg::mode_t                   mode_c;

	// stage 3: channel differences times offset
	logic [cgc_pkg::NUM_CHAN-1:0][cgc_pkg::CHAN_W-1:0] lo_c, hi_c, mag_c;
	logic [cgc_pkg::NUM_CHAN-1:0][cgc_pkg::PROD_W-1:0] prod_c;
	logic [cgc_pkg::NUM_CHAN-1:0]                      neg_c;

	assign rdy3     = !v_s3 || tok_rdy;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		bar_end = {1'b0, caption_left} + {1'b0, caption_width};
		mn_c    = (icon_width < caption_width) ? icon_width : caption_width;
		rs_c    = {1'b0, caption_left} + {1'b0, mn_c};
		rest_c  = {2'b00, caption_width} - {2'b00, buttons_width} - {2'b00, mn_c};
		span_c  = rest_c[cgc_pkg::COORD_BITS+1] ? '0 : rest_c[cgc_pkg::COORD_BITS-1:0];
		in_bar  = (caption_width != '0) && (column >= {1'b0, caption_left})
			&& (column < bar_end);
	end

	always_comb begin
		dd_c = {1'b0, col_s1} - {1'b0, rs_s1};
		if (dd_c[cgc_pkg::COL_W] || span_s1 == '0) begin
			mode_c = cgc_pkg::MODE_START;
		end else if (dd_c[cgc_pkg::COL_W-1:0] >= {1'b0, span_s1}) begin
			mode_c = cgc_pkg::MODE_END;
		end else begin
			mode_c = cgc_pkg::MODE_BLEND;
		end
	end

	always_comb begin
		for (int c = 0; c < cgc_pkg::NUM_CHAN; c++) begin
			lo_c[c]  = start_color[c*cgc_pkg::CHAN_W +: cgc_pkg::CHAN_W];
			hi_c[c]  = end_color[c*cgc_pkg::CHAN_W +: cgc_pkg::CHAN_W];
			neg_c[c] = hi_c[c] < lo_c[c];
			mag_c[c] = neg_c[c] ? (lo_c[c] - hi_c[c]) : (hi_c[c] - lo_c[c]);
			// zero outside the ramp so the divider cells see a clean remainder
			prod_c[c] = (mode_s2 == cgc_pkg::MODE_BLEND) ? mag_c[c] * d_s2 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			// drop columns outside the bar right here
			if (rdy1) begin
				v_s1 <= in_valid && in_bar;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			col_s1    <= column;
			rs_s1     <= rs_c;
			span_s1   <= span_c;
			top_s1    <= top;
			height_s1 <= height;
		end
		if (rdy2) begin
			col_s2    <= col_s1;
			top_s2    <= top_s1;
			height_s2 <= height_s1;
			span_s2   <= span_s1;
			mode_s2   <= mode_c;
			d_s2      <= dd_c[cgc_pkg::COORD_BITS-1:0];
		end
		if (rdy3) begin
			tok_s3.col    <= col_s2;
			tok_s3.top    <= top_s2;
			tok_s3.height <= height_s2;
			tok_s3.mode   <= mode_s2;
			tok_s3.neg    <= neg_c;
			tok_s3.dvs    <= {1'b0, span_s2, {cgc_pkg::CHAN_W{1'b0}}};
			tok_s3.rem    <= prod_c;
			tok_s3.quo    <= '0;
		end
	end

	assign tok_vld = v_s3;
	assign tok     = tok_s3;

endmodule

`default_nettype wire

@@ hw/rtl/cgc_div_cell.sv @@
`default_nettype none
`include "assert_macros.svh"

module cgc_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	output logic           in_rdy,
	input  cgc_pkg::tok_t  in_tok,
	output logic           out_vld,
	input  logic           out_rdy,
	output cgc_pkg::tok_t  out_tok
);

	logic                               vld_q;
	cgc_pkg::tok_t                      tok_q;
	cgc_pkg::tok_t                      nxt;
	logic [cgc_pkg::PROD_W-1:0]         dvs_half;
	logic [cgc_pkg::NUM_CHAN-1:0]       ge;

	assign in_rdy = !vld_q || out_rdy;

	// one restoring step per cell: try the shifted divisor, keep one quotient bit
	always_comb begin
		nxt      = in_tok;
		dvs_half = in_tok.dvs[cgc_pkg::DVS_W-1:1];
		for (int c = 0; c < cgc_pkg::NUM_CHAN; c++) begin
			ge[c]      = in_tok.rem[c] >= dvs_half;
			nxt.rem[c] = ge[c] ? (in_tok.rem[c] - dvs_half) : in_tok.rem[c];
			nxt.quo[c] = {in_tok.quo[c][cgc_pkg::CHAN_W-2:0], ge[c]};
		end
		nxt.dvs = {1'b0, dvs_half};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_rdy) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy) begin
			tok_q <= nxt;
		end
	end

	assign out_vld = vld_q;
	assign out_tok = tok_q;

	`ASSERT_IMPL(a_rem_bound, vld_q && tok_q.mode == cgc_pkg::MODE_BLEND, (tok_q.rem[0] < tok_q.dvs) && (tok_q.rem[1] < tok_q.dvs) && (tok_q.rem[2] < tok_q.dvs), "divider remainder not below divisor")

endmodule

`default_nettype wire

@@ hw/rtl/caption_gradient_column_unit.sv @@
`default_nettype none
`include "assert_macros.svh"

// Title bar gradient: one word in on the column channel is one pixel column of a bar
// with its geometry; one word out on the line channel is the vertical line to paint.
// Columns outside the bar (or any column of a zero-width bar) are dropped and give
// no word. The unit takes one column every cycle while the line side keeps up, and
// each taken column passes three front stages (bar test and ramp bounds, column
// classification, channel difference times offset), a chain of eight divider cells
// that each settle one quotient bit of offset*(end-start)/span for all three
// channels, and the output register on its way out as a line. Every stage keeps
// its own valid bit and moves up into an empty slot, so a stalled line word only
// holds the chain once all stages are full. start_color (address 0) and end_color
// (address 4) are plain APB registers; write them only while no column is in flight.

module caption_gradient_column_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cgc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [cgc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [cgc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	// column words
	input  logic                              col_valid,
	output logic                              col_ready,
	input  logic [cgc_pkg::COL_W-1:0]         column,
	input  logic [cgc_pkg::COORD_BITS-1:0]    caption_left,
	input  logic [cgc_pkg::COORD_BITS-1:0]    caption_width,
	input  logic [cgc_pkg::COORD_BITS-1:0]    icon_width,
	input  logic [cgc_pkg::COORD_BITS-1:0]    buttons_width,
	input  logic [cgc_pkg::COORD_BITS-1:0]    top,
	input  logic [cgc_pkg::COORD_BITS-1:0]    height,
	// line words
	output logic                              line_valid,
	input  logic                              line_ready,
	output logic [cgc_pkg::COL_W-1:0]         line_x,
	output logic [cgc_pkg::COORD_BITS-1:0]    line_top,
	output logic [cgc_pkg::COORD_BITS-1:0]    line_height,
	output logic [cgc_pkg::COLOR_W-1:0]       color
);

	localparam int N = cgc_pkg::NUM_CELLS;

	logic [cgc_pkg::COLOR_W-1:0]      start_color_q, end_color_q;
	cgc_pkg::reg_idx_t                reg_idx;

	logic [N:0]                       c_vld, c_rdy;
	cgc_pkg::tok_t                    c_tok [0:N];
	cgc_pkg::tok_t                    last_tok;

	logic                             line_valid_q;
	logic [cgc_pkg::COL_W-1:0]        line_x_q;
	logic [cgc_pkg::COORD_BITS-1:0]   line_top_q, line_height_q;
	logic [cgc_pkg::COLOR_W-1:0]      color_q, color_c;
	logic [cgc_pkg::CHAN_W-1:0]       lo_c, q_c;
	logic [cgc_pkg::CHAN_W-1:0]       red_lo, red_hi;
	logic                             ld;

	// ---- configuration registers ----
	assign pready  = 1'b1;
	assign reg_idx = cgc_pkg::reg_idx_t'(paddr[cgc_pkg::APB_ADDR_W-1]);

	always_comb begin
		case (reg_idx)
			cgc_pkg::REG_START_COLOR: prdata = cgc_pkg::APB_DATA_W'(start_color_q);
			cgc_pkg::REG_END_COLOR:   prdata = cgc_pkg::APB_DATA_W'(end_color_q);
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_color_q <= cgc_pkg::START_COLOR_RST;
			end_color_q   <= cgc_pkg::END_COLOR_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				cgc_pkg::REG_START_COLOR: start_color_q <= pwdata[cgc_pkg::COLOR_W-1:0];
				cgc_pkg::REG_END_COLOR:   end_color_q   <= pwdata[cgc_pkg::COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- front stages: geometry, classification, products ----
	cgc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (col_valid),
		.in_ready      (col_ready),
		.column        (column),
		.caption_left  (caption_left),
		.caption_width (caption_width),
		.icon_width    (icon_width),
		.buttons_width (buttons_width),
		.top           (top),
		.height        (height),
		.start_color   (start_color_q),
		.end_color     (end_color_q),
		.tok_vld       (c_vld[0]),
		.tok_rdy       (c_rdy[0]),
		.tok           (c_tok[0])
	);

	// ---- divider chain: one quotient bit per cell, MSB first ----
	for (genvar i = 0; i < N; i++) begin : g_cell
		cgc_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (c_vld[i]),
			.in_rdy  (c_rdy[i]),
			.in_tok  (c_tok[i]),
			.out_vld (c_vld[i+1]),
			.out_rdy (c_rdy[i+1]),
			.out_tok (c_tok[i+1])
		);
	end

	// ---- output register ----
	assign last_tok = c_tok[N];
	assign ld       = !line_valid_q || line_ready;
	assign c_rdy[N] = ld;

	// pick the colour; blend adds or subtracts the truncated quotient per channel
	always_comb begin
		color_c = start_color_q;
		lo_c    = '0;
		q_c     = '0;
		case (last_tok.mode)
			cgc_pkg::MODE_START: color_c = start_color_q;
			cgc_pkg::MODE_END:   color_c = end_color_q;
			cgc_pkg::MODE_BLEND: begin
				for (int c = 0; c < cgc_pkg::NUM_CHAN; c++) begin
					lo_c = start_color_q[c*cgc_pkg::CHAN_W +: cgc_pkg::CHAN_W];
					q_c  = last_tok.quo[c];
					color_c[c*cgc_pkg::CHAN_W +: cgc_pkg::CHAN_W] =
						last_tok.neg[c] ? (lo_c - q_c) : (lo_c + q_c);
				end
			end
			default: color_c = start_color_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= 1'b0;
		end else if (ld) begin
			line_valid_q <= c_vld[N];
		end
	end

	// hold the payload while the line side stalls
	always_ff @(posedge clk) begin
		if (ld && c_vld[N]) begin
			line_x_q      <= last_tok.col;
			line_top_q    <= last_tok.top;
			line_height_q <= last_tok.height;
			color_q       <= color_c;
		end
	end

	assign line_valid  = line_valid_q;
	assign line_x      = line_x_q;
	assign line_top    = line_top_q;
	assign line_height = line_height_q;
	assign color       = color_q;

	// red endpoints for the range check below
	assign red_lo = start_color_q[cgc_pkg::COLOR_W-1 -: cgc_pkg::CHAN_W];
	assign red_hi = end_color_q[cgc_pkg::COLOR_W-1 -: cgc_pkg::CHAN_W];

	`ASSERT_NEXT(a_blend_in_range, ld && c_vld[N] && last_tok.mode == cgc_pkg::MODE_BLEND, (color[23:16] >= red_lo && color[23:16] <= red_hi) || (color[23:16] <= red_lo && color[23:16] >= red_hi), "blended red outside its endpoints")
	`ASSERT_IMPL(a_ready_when_empty, !line_valid_q, col_ready, "column side stalled with empty line register")
	`ASSERT_IMPL(a_stall_only_full, !col_ready, line_valid_q && !line_ready && (&c_vld), "column side stalled with a hole in the chain")

endmodule

`default_nettype wire

@@ verif/caption_gradient_column_unit_test.sv @@
`default_nettype none

// Gradient unit check: a directed pass over the bar geometry corners with the reset
// colors, ramp sweeps at the color extremes, a sender pause, then random bars over
// several color settings. Every accepted column word is shaded here and any line
// it gives is queued; every line word out is checked against the oldest queued line.
module caption_gradient_column_unit_test;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 12;
	// Columns outside the bar are dropped at the first stage, so once no line is pending
	// the spare idle cycles below leave the unit empty before a register write.
	localparam int DRAIN_CYCLES   = 30;
	localparam int RANDOM_COLUMNS = 700;
	localparam int RANDOM_PHASES  = 5;

	typedef struct packed {
		logic [cgc_pkg::COL_W-1:0]      column;
		logic [cgc_pkg::COORD_BITS-1:0] caption_left;
		logic [cgc_pkg::COORD_BITS-1:0] caption_width;
		logic [cgc_pkg::COORD_BITS-1:0] icon_width;
		logic [cgc_pkg::COORD_BITS-1:0] buttons_width;
		logic [cgc_pkg::COORD_BITS-1:0] top;
		logic [cgc_pkg::COORD_BITS-1:0] height;
	} column_t;

	typedef struct packed {
		logic [cgc_pkg::COL_W-1:0]      x;
		logic [cgc_pkg::COORD_BITS-1:0] top;
		logic [cgc_pkg::COORD_BITS-1:0] height;
		logic [cgc_pkg::COLOR_W-1:0]    color;
	} line_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               psel = 1'b0;
	logic                               penable = 1'b0;
	logic                               pwrite = 1'b0;
	logic [cgc_pkg::APB_ADDR_W-1:0]     paddr = '0;
	logic [cgc_pkg::APB_DATA_W-1:0]     pwdata = '0;
	logic [cgc_pkg::APB_DATA_W-1:0]     prdata;
	logic                               pready;
	logic                               col_valid = 1'b0;
	logic                               col_ready;
	logic [cgc_pkg::COL_W-1:0]          column = '0;
	logic [cgc_pkg::COORD_BITS-1:0]     caption_left = '0;
	logic [cgc_pkg::COORD_BITS-1:0]     caption_width = '0;
	logic [cgc_pkg::COORD_BITS-1:0]     icon_width = '0;
	logic [cgc_pkg::COORD_BITS-1:0]     buttons_width = '0;
	logic [cgc_pkg::COORD_BITS-1:0]     top = '0;
	logic [cgc_pkg::COORD_BITS-1:0]     height = '0;
	logic                               line_valid;
	logic                               line_ready = 1'b0;
	logic [cgc_pkg::COL_W-1:0]          line_x;
	logic [cgc_pkg::COORD_BITS-1:0]     line_top;
	logic [cgc_pkg::COORD_BITS-1:0]     line_height;
	logic [cgc_pkg::COLOR_W-1:0]        color;

	// Shadow copy of the two color registers.
	logic [cgc_pkg::COLOR_W-1:0]        start_shadow = cgc_pkg::START_COLOR_RST;
	logic [cgc_pkg::COLOR_W-1:0]        end_shadow = cgc_pkg::END_COLOR_RST;

	line_t                              pending_lines[$];
	int                                 errors = 0;
	int                                 columns_sent = 0;
	int                                 lines_seen = 0;
	int                                 color_settings = 1;
	int                                 ready_hold = 0;
	bit                                 steady = 1'b0;

	caption_gradient_column_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.col_valid     (col_valid),
		.col_ready     (col_ready),
		.column        (column),
		.caption_left  (caption_left),
		.caption_width (caption_width),
		.icon_width    (icon_width),
		.buttons_width (buttons_width),
		.top           (top),
		.height        (height),
		.line_valid    (line_valid),
		.line_ready    (line_ready),
		.line_x        (line_x),
		.line_top      (line_top),
		.line_height   (line_height),
		.color         (color)
	);

	always #HALF_PERIOD clk = ~clk;

	// Hard stop far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("%0t: timeout, %0d lines still pending", $time, pending_lines.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// Idle length for either side: mostly none, some short, a few long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Shade one column: returns 1 and the line when the column falls inside the bar.
	function automatic bit shade_column(input column_t c, output line_t ln);
		int col, left, width, icon, buttons;
		int ramp_lo, ramp_hi, span, offs, lo, hi, v, ch;
		logic [cgc_pkg::COLOR_W-1:0] rgb;
		col = int'(c.column);
		left = int'(c.caption_left);
		width = int'(c.caption_width);
		icon = int'(c.icon_width);
		buttons = int'(c.buttons_width);
		ln = '0;
		if (width == 0 || col < left || col >= left + width)
			return 1'b0;
		ramp_lo = left + (icon < width ? icon : width);
		ramp_hi = left + width - buttons;
		if (ramp_hi < ramp_lo)
			ramp_hi = ramp_lo;
		span = ramp_hi - ramp_lo;
		if (col < ramp_lo || span <= 0) begin
			rgb = start_shadow;
		end else if (col >= ramp_hi) begin
			rgb = end_shadow;
		end else begin
			offs = col - ramp_lo;
			for (ch = 0; ch < cgc_pkg::NUM_CHAN; ch++) begin
				lo = int'(start_shadow[ch*cgc_pkg::CHAN_W +: cgc_pkg::CHAN_W]);
				hi = int'(end_shadow[ch*cgc_pkg::CHAN_W +: cgc_pkg::CHAN_W]);
				// signed int division truncates toward zero
				v = lo + ((hi - lo) * offs) / span;
				rgb[ch*cgc_pkg::CHAN_W +: cgc_pkg::CHAN_W] = v[cgc_pkg::CHAN_W-1:0];
			end
		end
		ln.x = c.column;
		ln.top = c.top;
		ln.height = c.height;
		ln.color = rgb;
		return 1'b1;
	endfunction

	function automatic column_t make_column(input int col, input int left, input int width,
			input int icon, input int buttons, input int t, input int h);
		column_t c;
		c.column = cgc_pkg::COL_W'(col);
		c.caption_left = cgc_pkg::COORD_BITS'(left);
		c.caption_width = cgc_pkg::COORD_BITS'(width);
		c.icon_width = cgc_pkg::COORD_BITS'(icon);
		c.buttons_width = cgc_pkg::COORD_BITS'(buttons);
		c.top = cgc_pkg::COORD_BITS'(t);
		c.height = cgc_pkg::COORD_BITS'(h);
		return c;
	endfunction

	// Random bar with mostly in-bar columns; the rest fall anywhere, left of it or past it.
	function automatic column_t random_column();
		column_t c;
		int left, width, icon, buttons, col, r;
		left = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 300) : $urandom_range(0, 4095);
		r = $urandom_range(0, 99);
		if (r < 4)
			width = 0;
		else if (r < 60)
			width = $urandom_range(1, 64);
		else if (r < 85)
			width = $urandom_range(65, 600);
		else
			width = $urandom_range(1, 4095);
		r = $urandom_range(0, 99);
		icon = (r < 10) ? 0 : (r < 75) ? $urandom_range(0, width / 3) :
			(r < 90) ? $urandom_range(0, width) : $urandom_range(0, 4095);
		r = $urandom_range(0, 99);
		buttons = (r < 10) ? 0 : (r < 75) ? $urandom_range(0, width / 3) :
			(r < 90) ? $urandom_range(0, width) : $urandom_range(0, 4095);
		r = $urandom_range(0, 99);
		if (width > 0 && r < 85)
			col = left + $urandom_range(0, width - 1);
		else if (r < 92 || left == 0)
			col = $urandom_range(0, 8191);
		else if (r < 96)
			col = $urandom_range(0, left - 1);
		else
			col = $urandom_range(left + width, 8191);
		return make_column(col, left, width, icon, buttons,
			$urandom_range(0, 4095), $urandom_range(0, 4095));
	endfunction

	// Present one column word, hold it until taken, then queue its line if it has one.
	task automatic send_column(input column_t c, output bit has_line);
		line_t ln;
		int gap;
		column <= c.column;
		caption_left <= c.caption_left;
		caption_width <= c.caption_width;
		icon_width <= c.icon_width;
		buttons_width <= c.buttons_width;
		top <= c.top;
		height <= c.height;
		col_valid <= 1'b1;
		do @(posedge clk); while (!col_ready);
		columns_sent++;
		has_line = shade_column(c, ln);
		if (has_line)
			pending_lines.push_back(ln);
		gap = idle_len();
		if (gap > 0) begin
			col_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, wait out every pending line, then idle a little longer.
	task automatic drain_lines();
		col_valid <= 1'b0;
		while (pending_lines.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one color register, then read it back.
	task automatic write_color(input cgc_pkg::reg_idx_t idx,
			input logic [cgc_pkg::COLOR_W-1:0] rgb);
		logic [cgc_pkg::APB_ADDR_W-1:0] addr;
		addr = cgc_pkg::APB_ADDR_W'(int'(idx) * 4);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		// upper byte is junk; the register keeps only 24 bits
		pwdata <= {8'($urandom), rgb};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == cgc_pkg::REG_START_COLOR)
			start_shadow = rgb;
		else
			end_shadow = rgb;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[cgc_pkg::COLOR_W-1:0] !== rgb) begin
			$display("%0t: readback of %s expected %06h actual %06h", $time, idx.name(),
				rgb, prdata[cgc_pkg::COLOR_W-1:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_colors(input logic [cgc_pkg::COLOR_W-1:0] s,
			input logic [cgc_pkg::COLOR_W-1:0] e);
		drain_lines();
		write_color(cgc_pkg::REG_START_COLOR, s);
		write_color(cgc_pkg::REG_END_COLOR, e);
		color_settings++;
	endtask

	// Bar corners and every special case, with the reset colors still in place.
	task automatic test_geometry_corners();
		column_t cases[$];
		bit has;
		cases.push_back(make_column(0, 0, 1, 0, 0, 0, 0));
		cases.push_back(make_column(5, 5, 0, 0, 0, 1, 1));            // zero width
		cases.push_back(make_column(9, 10, 20, 0, 0, 2, 2));          // left of bar
		cases.push_back(make_column(30, 10, 20, 0, 0, 3, 3));         // first past bar
		cases.push_back(make_column(4095, 4095, 4095, 0, 0, 4095, 4095));
		cases.push_back(make_column(8189, 4095, 4095, 0, 0, 0, 4095));
		cases.push_back(make_column(8190, 4095, 4095, 0, 0, 4095, 0));
		cases.push_back(make_column(8191, 4095, 4095, 4095, 4095, 4095, 4095));
		cases.push_back(make_column(149, 100, 50, 4095, 0, 7, 7));    // icon wider than bar
		cases.push_back(make_column(100, 100, 50, 60, 10, 8, 8));
		cases.push_back(make_column(105, 10, 100, 30, 90, 9, 9));     // buttons past ramp start
		cases.push_back(make_column(20, 10, 100, 30, 90, 9, 9));
		cases.push_back(make_column(95, 10, 100, 10, 20, 11, 11));    // in button strip
		cases.push_back(make_column(90, 10, 100, 10, 20, 12, 12));    // ramp end
		cases.push_back(make_column(15, 10, 100, 10, 20, 13, 13));    // inside icon strip
		cases.push_back(make_column(19, 10, 100, 10, 20, 14, 14));    // last icon column
		cases.push_back(make_column(55, 10, 100, 10, 20, 15, 15));    // mid ramp
		cases.push_back(make_column(109, 10, 100, 0, 0, 16, 16));     // last column, no strips
		cases.push_back(make_column(3000, 0, 4095, 0, 4095, 17, 17)); // buttons fill the bar
		cases.push_back(make_column(4094, 0, 4095, 4095, 0, 18, 18)); // icon fills the bar
		cases.push_back(make_column(2048, 1, 4095, 1, 1, 2730, 1365));
		cases.push_back(make_column(4096, 0, 4095, 0, 0, 0, 0));
		foreach (cases[i])
			send_column(cases[i], has);
		drain_lines();
	endtask

	// Full-scale rising and falling ramps, then equal ends.
	task automatic test_color_extremes();
		logic [cgc_pkg::COLOR_W-1:0] ends[3][2];
		bit has;
		int k, x;
		ends = '{'{24'h000000, 24'hFFFFFF}, '{24'hFFFFFF, 24'h000000},
			'{24'h5A5A5A, 24'h5A5A5A}};
		for (k = 0; k < 3; k++) begin
			set_colors(ends[k][0], ends[k][1]);
			for (x = 18; x <= 62; x++)
				send_column(make_column(x, 20, 40, 5, 7, x, 62 - x), has);
			send_column(make_column(8000, 3000, 4095, 0, 0, 4095, 4095), has);
		end
		drain_lines();
	endtask

	// Stream steadily, hold off until the unit is empty, then stream again.
	task automatic test_sender_pause();
		bit has;
		int k;
		steady = 1'b1;
		for (k = 0; k < 40; k++)
			send_column(random_column(), has);
		col_valid <= 1'b0;
		while (pending_lines.size() != 0)
			@(posedge clk);
		@(posedge clk);
		for (k = 0; k < 40; k++)
			send_column(random_column(), has);
		steady = 1'b0;
		drain_lines();
	endtask

	// Random bars in phases, each under fresh random colors; one phase runs with no idling.
	task automatic test_random_bars();
		bit has;
		int phase, k;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_colors(24'($urandom), 24'($urandom));
			steady = (phase == 2);
			for (k = 0; k < RANDOM_COLUMNS / RANDOM_PHASES; k++)
				send_column(random_column(), has);
		end
		steady = 1'b0;
		drain_lines();
	endtask

	// Line side: stall at random, hold ready steady when asked.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			line_ready <= 1'b0;
		end else begin
			line_ready <= 1'b1;
			if ($urandom_range(0, 99) < 15)
				ready_hold <= idle_len();
		end
	end

	// Check every line word taken against the oldest pending line.
	always @(posedge clk) begin
		line_t want;
		if (arst_n && line_valid && line_ready) begin
			lines_seen++;
			if (pending_lines.size() == 0) begin
				$display("%0t: unexpected line x=%0d top=%0d height=%0d color=%06h", $time,
					line_x, line_top, line_height, color);
				errors++;
			end else begin
				want = pending_lines.pop_front();
				if (line_x !== want.x) begin
					$display("%0t: line_x expected %0d actual %0d", $time, want.x, line_x);
					errors++;
				end
				if (line_top !== want.top) begin
					$display("%0t: line_top expected %0d actual %0d", $time, want.top,
						line_top);
					errors++;
				end
				if (line_height !== want.height) begin
					$display("%0t: line_height expected %0d actual %0d", $time, want.height,
						line_height);
					errors++;
				end
				if (color !== want.color) begin
					$display("%0t: color expected %06h actual %06h (x=%0d)", $time,
						want.color, color, want.x);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_geometry_corners();
		test_color_extremes();
		test_sender_pause();
		test_random_bars();
		if (pending_lines.size() != 0) begin
			$display("%0t: %0d lines never arrived", $time, pending_lines.size());
			errors++;
		end
		$display("Sent %0d column words under %0d color settings; checked %0d line words.",
			columns_sent, color_settings, lines_seen);
		$display("Covered bar corners, strip overlaps, full-scale ramps and random bars.");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/cgc_pkg.sv
hw/rtl/cgc_front.sv
hw/rtl/cgc_div_cell.sv
hw/rtl/caption_gradient_column_unit.sv
verif/caption_gradient_column_unit_test.sv
